FILE: design/box_filter_3x3_zero_pad_assert.svh
// Assertion macros for the checker file
`ifndef BOX_FILTER_3X3_ZERO_PAD_ASSERT_SVH
`define BOX_FILTER_3X3_ZERO_PAD_ASSERT_SVH

// Check a property only while out of reset
`define BF3_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bf3 check failed");

// Check a property on every edge, reset included
`define BF3_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("bf3 reset check failed");

`endif

FILE: design/bf3_pkg.sv
package bf3_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam logic [10:0] WIDTH_RESET   = 11'd640;
  localparam int unsigned QUEUE_DEPTH   = 4;

  // floor(s / 9) as (s * 7282) >> 16, exact for s below 2296
  localparam logic [12:0] RECIP_9     = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;

  // Work word from the front to the back
  typedef struct packed {
    logic [9:0] colsum;   // top + mid + bottom of the new column
    logic [9:0] col;      // column of the input word, low bits
    logic [9:0] wm1;      // effective width minus one, low bits
    logic       first;    // column zero: window starts empty
    logic       row_end;  // last word of the row
    logic       rs1;      // at least one row already seen
    logic       flush;    // flush word
  } bf3_item_t;

  function automatic logic [7:0] mean9(input logic [11:0] sum);
    logic [24:0] prod;
    prod = {13'd0, sum} * {12'd0, RECIP_9};
    return prod[RECIP_SHIFT +: 8];
  endfunction

endpackage

FILE: design/bf3_front.sv
module bf3_front import bf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [10:0]      cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_mode,
  input  logic [7:0]       in_pixel,
  input  logic [2:0]       q_count,
  output logic             push_valid,
  output bf3_item_t        push_item
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (AW + 1 > 11) ? AW + 1 : 11;

  logic [15:0]   mem [MAX_WIDTH];
  logic [15:0]   rd_r;
  logic [10:0]   width_r;
  logic [AW-1:0] col_r;
  logic [1:0]    rows_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  logic          s1_valid_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    s1_px_r;
  logic          s1_rs1_r;
  logic          s1_rs2_r;
  logic [9:0]    s1_col_r;
  logic [9:0]    s1_wm1_r;
  logic          s1_first_r;
  logic          s1_row_end_r;
  logic          s1_flush_r;

  logic [WW-1:0] w_ext;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] wm1;
  logic          row_end;
  logic          acc;
  logic [7:0]    px;
  logic [7:0]    top;
  logic [7:0]    mid;

  // Clamp the width and find the row end
  always_comb begin
    w_ext = WW'(width_r);
    if (w_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    wm1     = w_eff - WW'(1);
    row_end = WW'(col_r) >= wm1;
  end

  assign in_tready = !clr_active_r && ({2'b00, s1_valid_r} + q_count) < 3'(QUEUE_DEPTH);
  assign acc       = in_tvalid && in_tready;
  assign px        = in_mode ? 8'd0 : in_pixel;

  // Control: width, column, rows, clearing pass, stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= WIDTH_RESET;
      col_r        <= '0;
      rows_r       <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      s1_valid_r <= acc;
      if (acc) begin
        if (row_end) begin
          col_r <= '0;
          if (in_mode) begin
            rows_r <= '0;
          end else if (rows_r < 2'd2) begin
            rows_r <= rows_r + 2'd1;
          end
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r    <= col_r;
      s1_px_r      <= px;
      s1_rs1_r     <= rows_r >= 2'd1;
      s1_rs2_r     <= rows_r >= 2'd2;
      s1_col_r     <= 10'(col_r);
      s1_wm1_r     <= wm1[9:0];
      s1_first_r   <= col_r == '0;
      s1_row_end_r <= row_end;
      s1_flush_r   <= in_mode;
    end
  end

  // Line store: older row in the high byte, newer row in the low byte
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (s1_valid_r) begin
      mem[s1_addr_r] <= {rd_r[7:0], s1_px_r};
    end
    if (acc) begin
      rd_r <= mem[col_r];
    end
  end

  // Rows above the frame read as zero
  assign top = s1_rs2_r ? rd_r[15:8] : 8'd0;
  assign mid = s1_rs1_r ? rd_r[7:0]  : 8'd0;

  assign push_valid           = s1_valid_r;
  assign push_item.colsum     = {2'b00, top} + {2'b00, mid} + {2'b00, s1_px_r};
  assign push_item.col        = s1_col_r;
  assign push_item.wm1        = s1_wm1_r;
  assign push_item.first      = s1_first_r;
  assign push_item.row_end    = s1_row_end_r;
  assign push_item.rs1        = s1_rs1_r;
  assign push_item.flush      = s1_flush_r;

endmodule

FILE: design/bf3_fifo.sv
module bf3_fifo import bf3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  bf3_item_t push_item,
  input  logic      pop,
  output logic      head_valid,
  output bf3_item_t head_item,
  output logic [2:0] count
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  bf3_item_t     buf_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [2:0]    count_r;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + {2'b00, push_valid} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = count_r != 3'd0;
  assign head_item  = buf_r[rd_ptr_r];
  assign count      = count_r;

endmodule

FILE: design/bf3_back.sv
module bf3_back import bf3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  bf3_item_t  head_item,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_mean,
  output logic [9:0] out_col,
  output logic       out_last,
  output logic       out_fend
);

  logic [9:0]  cs1_r, cs2_r;
  logic        phase_r;
  logic        out_valid_r;
  logic [7:0]  mean_r;
  logic [9:0]  col_r;
  logic        last_r;
  logic        fend_r;

  logic        can_emit;
  logic        emit0;
  logic        go0;
  logic        go1;
  logic [9:0]  n0, n1;
  logic [11:0] sum0;
  logic [11:0] sum1;

  assign can_emit = !out_valid_r || out_tready;
  assign emit0    = head_item.rs1 && !head_item.first;
  assign go0      = head_valid && !phase_r && (!emit0 || can_emit);
  assign go1      = head_valid && phase_r && can_emit;
  assign n0       = head_item.first ? 10'd0 : cs1_r;
  assign n1       = head_item.first ? 10'd0 : cs2_r;
  assign sum0     = {2'b00, n0} + {2'b00, n1} + {2'b00, head_item.colsum};
  assign sum1     = {2'b00, cs1_r} + {2'b00, cs2_r};
  assign pop      = (go0 && !(head_item.rs1 && head_item.row_end)) || go1;

  // Window column sums and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs1_r   <= '0;
      cs2_r   <= '0;
      phase_r <= 1'b0;
    end else if (go0) begin
      cs1_r <= n1;
      cs2_r <= head_item.colsum;
      if (head_item.rs1 && head_item.row_end) begin
        phase_r <= 1'b1;
      end
    end else if (go1) begin
      cs1_r   <= cs2_r;
      cs2_r   <= '0;
      phase_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((go0 && emit0) || go1) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go0 && emit0) begin
      mean_r <= mean9(sum0);
      col_r  <= head_item.col - 10'd1;
      last_r <= !head_item.row_end;
      fend_r <= 1'b0;
    end else if (go1) begin
      mean_r <= mean9(sum1);
      col_r  <= head_item.wm1;
      last_r <= 1'b1;
      fend_r <= head_item.flush;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_mean   = mean_r;
  assign out_col    = col_r;
  assign out_last   = last_r;
  assign out_fend   = fend_r;

endmodule

FILE: design/box_filter_3x3_zero_pad.sv
// 3x3 mean filter, zero padded, on a raster stream of 8-bit pixels.
// Input words: in_tdata is the pixel, in_tuser is the flush flag. After the
// last image row send one row of flush words; they stand for the padding row
// and close the frame. cfg_wr_en/cfg_wr_data set the row width (clamped to
// 2..MAX_WIDTH); write it only while the block is idle.
// Output words: mean, column, tlast on the last result of an input word,
// tuser on the last pixel of the frame. Row r-1 comes out while row r goes in.
// Path: an accepted input word goes through the line store read, then the
// queue, then the registered mean stage, before its result word is valid.
// Throughput: one input word per cycle while in_tready is high; the word at
// the end of a row yields two results, one in each back-end phase. The queue
// absorbs this for a few rows; on a long stream in_tready then drops once
// per row. Reset: the line store is cleared one address a cycle, over all
// MAX_WIDTH addresses, with in_tready low; the width returns to 640.
// A stalled receiver holds the output word; the queue fills and then
// in_tready drops until results drain.
module box_filter_3x3_zero_pad import bf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] mean_value, [17:8] out_col, zero above
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // [0] frame_end
);

  logic       push_valid;
  bf3_item_t  push_item;
  logic       pop;
  logic       head_valid;
  bf3_item_t  head_item;
  logic [2:0] q_count;
  logic [7:0] mean;
  logic [9:0] col;

  bf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_mode     (in_tuser),
    .in_pixel    (in_tdata),
    .q_count     (q_count),
    .push_valid  (push_valid),
    .push_item   (push_item)
  );

  bf3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  bf3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_mean   (mean),
    .out_col    (col),
    .out_last   (out_tlast),
    .out_fend   (out_tuser)
  );

  assign out_tdata = {6'd0, col, mean};

endmodule

FILE: design/bf3_checker.sv
`include "box_filter_3x3_zero_pad_assert.svh"

module bf3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled result word holds
  `BF3_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // The frame closes on the final result of a word
  `BF3_ASSERT(a_fend_last, out_tvalid && out_tuser |-> out_tlast)
  // Clearing pass blocks input right after reset
  `BF3_ASSERT_ALWAYS(a_rst_ready, !rst_n |=> !in_tready)
  // No result right after reset
  `BF3_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid)

endmodule

bind box_filter_3x3_zero_pad bf3_checker u_bf3_checker (.*);
